@@ src/gate_array_interrupt_aggregator_core_assert.svh @@
// assertion macros used by the checker file
`ifndef GATE_ARRAY_INTERRUPT_AGGREGATOR_CORE_ASSERT_SVH
`define GATE_ARRAY_INTERRUPT_AGGREGATOR_CORE_ASSERT_SVH

// checked only outside reset
`define GAIA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define GAIA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/gaia_pkg.sv @@
package gaia_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LINE  = 2'd2
  } gaia_op_t;

  localparam logic [2:0] OFS_LCD_CTRL = 3'd1;
  localparam logic [2:0] OFS_IRQ      = 3'd2;
  localparam logic [2:0] OFS_LCD_CMD  = 3'd4;
  localparam logic [2:0] OFS_LCD_DATA = 3'd5;

  localparam logic [7:0] UNMAPPED_READ = 8'hff;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] offset;
    logic [7:0] wdata;
    logic [2:0] source;
    logic       level;
  } gaia_in_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
    logic       lcd_forward;
    logic       lcd_rs;
    logic       lcd_off;
  } gaia_out_t;

  // handoff from the input register to the engine
  typedef struct packed {
    logic     fire;
    gaia_in_t item;
  } gaia_issue_t;

endpackage

@@ src/gate_array_interrupt_aggregator_core.sv @@
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   in_data  (gaia_in_t: op offset wdata source level)
// out       output     out_valid/out_stall out_data (gaia_out_t: rdata irq lcd_forward ...)
//
// one transfer per cycle sustained while out_stall is low; each item passes from in to out
// through the input register, then engine logic into the result register
// rst_n is synchronous; it clears both valid flags and all gate array state
// a stalled result holds out_data; the input register still takes one item while empty
// in_stall rises only when both stages are full and the result is stalled
module gate_array_interrupt_aggregator_core
  import gaia_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  gaia_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output gaia_out_t out_data
);

  logic        in_valid_r;
  gaia_in_t    in_item_r;
  logic        fire;
  gaia_issue_t issue;
  gaia_out_t   result;

  // the engine runs the held item whenever the result register is free or draining
  assign fire     = in_valid_r && (!out_valid || !out_stall);
  assign in_stall = in_valid_r && !fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  assign issue.fire = fire;
  assign issue.item = in_item_r;

  // state and decode: mask, pending source, line levels, lcd control
  gaia_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .issue  (issue),
    .result (result)
  );

  // result register, loaded in the cycle the engine commits
  gaia_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ src/gaia_engine.sv @@
module gaia_engine
  import gaia_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  gaia_issue_t issue,
  output gaia_out_t   result
);

  logic [7:0] line_levels_r, line_levels_nxt;
  logic [7:0] enable_mask_r, enable_mask_nxt;
  logic [2:0] pending_r, pending_nxt;
  logic       lcd_off_r, lcd_off_nxt;
  logic       fwd;
  logic [7:0] rdata;
  logic [2:0] mask_idx;
  gaia_in_t   it;

  assign it       = issue.item;
  assign mask_idx = it.source - 3'd1;

  always_comb begin
    line_levels_nxt = line_levels_r;
    enable_mask_nxt = enable_mask_r;
    pending_nxt     = pending_r;
    lcd_off_nxt     = lcd_off_r;
    fwd             = 1'b0;
    rdata           = 8'd0;
    case (it.op)
      OP_READ: begin
        if (it.offset == OFS_IRQ) begin
          rdata       = {5'd0, pending_r};
          pending_nxt = 3'd0;
        end else if (it.offset == OFS_LCD_CMD || it.offset == OFS_LCD_DATA) begin
          fwd = 1'b1;
        end else begin
          rdata = UNMAPPED_READ;
        end
      end
      OP_WRITE: begin
        if (it.offset == OFS_LCD_CTRL) begin
          lcd_off_nxt = it.wdata[0];
        end else if (it.offset == OFS_IRQ) begin
          enable_mask_nxt = it.wdata;
          pending_nxt     = 3'd0;
        end else if (it.offset == OFS_LCD_CMD || it.offset == OFS_LCD_DATA) begin
          fwd = 1'b1;
        end
      end
      OP_LINE: begin
        if (it.level) begin
          // rising edge of an enabled source with nothing latched
          if (it.source != 3'd0 && !line_levels_r[it.source] &&
              enable_mask_r[mask_idx] && pending_r == 3'd0) begin
            pending_nxt = it.source;
          end
          line_levels_nxt[it.source] = 1'b1;
        end else begin
          line_levels_nxt[it.source] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_levels_r <= 8'd0;
      enable_mask_r <= 8'd0;
      pending_r     <= 3'd0;
      lcd_off_r     <= 1'b0;
    end else if (issue.fire) begin
      line_levels_r <= line_levels_nxt;
      enable_mask_r <= enable_mask_nxt;
      pending_r     <= pending_nxt;
      lcd_off_r     <= lcd_off_nxt;
    end
  end

  assign result.rdata       = rdata;
  assign result.irq         = (pending_nxt != 3'd0);
  assign result.lcd_forward = fwd;
  assign result.lcd_rs      = fwd & it.offset[0];
  assign result.lcd_off     = lcd_off_nxt;

endmodule

@@ src/gaia_out_stage.sv @@
module gaia_out_stage
  import gaia_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  gaia_out_t result,
  input  logic      out_stall,
  output logic      out_valid,
  output gaia_out_t out_data
);

  logic      valid_r;
  gaia_out_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ src/gaia_checker.sv @@
`include "gate_array_interrupt_aggregator_core_assert.svh"

module gaia_checker
  import gaia_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input gaia_out_t out_data
);

  `GAIA_ASSERT_RST(a_rst_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `GAIA_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(out_data),
    "stalled result changed")
  `GAIA_ASSERT(a_fwd_reads_zero,
    out_valid && out_data.lcd_forward |-> out_data.rdata == 8'd0,
    "lcd access with nonzero data")
  `GAIA_ASSERT(a_rs_needs_fwd,
    out_valid && out_data.lcd_rs |-> out_data.lcd_forward,
    "lcd_rs without lcd access")
  `GAIA_ASSERT(a_rdata_range,
    out_valid && out_data.rdata != UNMAPPED_READ |-> out_data.rdata[7:3] == 5'd0,
    "read data out of range")

endmodule

bind gate_array_interrupt_aggregator_core gaia_checker u_gaia_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ verif/tb.sv @@
module tb;
  import gaia_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // op code 3 is left unused by the block
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // offsets with no register behind them
  localparam logic [2:0] OFS_UNMAPPED_LO = 3'd0;
  localparam logic [2:0] OFS_UNMAPPED_MID = 3'd3;
  localparam logic [2:0] OFS_UNMAPPED_HI = 3'd7;
  localparam int unsigned MAX_REPORTS = 10;
  // pipeline is two stages deep; the settle wait is longer than that
  localparam int unsigned SETTLE_CYCLES = 6;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  gaia_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  gaia_out_t out_data;

  gate_array_interrupt_aggregator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gate array shadow state, updated in transfer order
  logic [7:0] line_lvl = '0;
  logic [7:0] irq_mask = '0;
  logic [2:0] latched_src = '0;
  logic [7:0] lcd_ctrl = '0;

  // results still owed by the block, oldest first
  gaia_out_t pending_results[$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned err_count = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_latches = 0;
  int unsigned n_src_reads = 0;
  int unsigned n_lcd_fwd = 0;
  int unsigned n_full_stalls = 0;

  // cycle count and long receiver hold-off window
  longint unsigned cycle_cnt = 0;
  longint unsigned hold_end = 0;

  // next-state and result of the gate array for one transfer
  function automatic gaia_out_t predict_result(gaia_in_t it);
    gaia_out_t  res;
    logic [7:0] src_bit;
    res = '0;
    src_bit = 8'd1 << it.source;
    case (it.op)
      OP_READ: begin
        if (it.offset == OFS_IRQ) begin
          res.rdata = {5'd0, latched_src};
          if (latched_src != '0) n_src_reads++;
          latched_src = '0;
        end else if (it.offset == OFS_LCD_CMD || it.offset == OFS_LCD_DATA) begin
          res.lcd_forward = 1'b1;
        end else begin
          res.rdata = UNMAPPED_READ;
        end
      end
      OP_WRITE: begin
        if (it.offset == OFS_LCD_CTRL) begin
          lcd_ctrl = it.wdata;
        end else if (it.offset == OFS_IRQ) begin
          irq_mask = it.wdata;
          latched_src = '0;
        end else if (it.offset == OFS_LCD_CMD || it.offset == OFS_LCD_DATA) begin
          res.lcd_forward = 1'b1;
        end
      end
      OP_LINE: begin
        if (it.level) begin
          // rising edge of an enabled source, nothing latched yet; source zero never latches
          if (it.source != '0 && (line_lvl & src_bit) == '0 &&
              irq_mask[it.source - 3'd1] && latched_src == '0) begin
            latched_src = it.source;
            n_latches++;
          end
          line_lvl = line_lvl | src_bit;
        end else begin
          line_lvl = line_lvl & ~src_bit;
        end
      end
      default: ;
    endcase
    res.irq = (latched_src != '0);
    res.lcd_rs = res.lcd_forward & it.offset[0];
    res.lcd_off = lcd_ctrl[0];
    if (res.lcd_forward) n_lcd_fwd++;
    return res;
  endfunction

  function automatic gaia_in_t make_item(logic [1:0] op, logic [2:0] offset,
                                         logic [7:0] wdata, logic [2:0] source,
                                         logic level);
    gaia_in_t it;
    it.op = op;
    it.offset = offset;
    it.wdata = wdata;
    it.source = source;
    it.level = level;
    return it;
  endfunction

  // mostly well-formed traffic: mask writes, line toggles, source reads
  function automatic gaia_in_t random_item();
    gaia_in_t    it;
    logic [31:0] rnd;
    int unsigned pick;
    rnd = $urandom;
    it = rnd[$bits(gaia_in_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 50) begin
      it.op = OP_LINE;
    end else if (pick < 75) begin
      it.op = OP_READ;
      if ($urandom_range(1) == 0) it.offset = OFS_IRQ;
    end else if (pick < 95) begin
      it.op = OP_WRITE;
      if ($urandom_range(2) == 0) it.offset = OFS_IRQ;
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  // cycle counter and receiver stall
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    out_stall <= (cycle_cnt < hold_end) || ($urandom_range(99) < stall_pct);
  end

  // one transfer in: optional idle gap, then hold valid until accepted
  task automatic send_item(input gaia_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) begin
      n_full_stalls++;
      @(posedge clk);
    end
    pending_results.push_back(predict_result(it));
    n_sent++;
  endtask

  // sender pauses until every result is back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    gaia_out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("[%0t] unexpected result transfer: rdata=%h irq=%b fwd=%b rs=%b off=%b",
                   $realtime, out_data.rdata, out_data.irq, out_data.lcd_forward,
                   out_data.lcd_rs, out_data.lcd_off);
      end else begin
        exp_res = pending_results.pop_front();
        n_checked++;
        if (out_data.rdata !== exp_res.rdata || out_data.irq !== exp_res.irq ||
            out_data.lcd_forward !== exp_res.lcd_forward ||
            out_data.lcd_rs !== exp_res.lcd_rs || out_data.lcd_off !== exp_res.lcd_off) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("[%0t] result %0d mismatch: rdata %h/%h irq %b/%b fwd %b/%b rs %b/%b off %b/%b (exp/got)",
                     $realtime, n_checked, exp_res.rdata, out_data.rdata, exp_res.irq,
                     out_data.irq, exp_res.lcd_forward, out_data.lcd_forward,
                     exp_res.lcd_rs, out_data.lcd_rs, exp_res.lcd_off, out_data.lcd_off);
        end
      end
    end
  end

  // every offset read, every offset but 6 written, latch rules, source zero, unused op
  task automatic test_register_window();
    idle_pct = 0;
    stall_pct = 0;
    for (int ofs = 0; ofs < 8; ofs++) send_item(make_item(OP_READ, ofs[2:0], 8'h00, 3'd7, 1'b1));
    send_item(make_item(OP_WRITE, OFS_LCD_CTRL, 8'hff, 3'd0, 1'b0));
    send_item(make_item(OP_WRITE, OFS_IRQ, 8'hff, 3'd0, 1'b0));
    send_item(make_item(OP_LINE, 3'd0, 8'hff, 3'd3, 1'b1));
    // second source rises while one is latched
    send_item(make_item(OP_LINE, 3'd0, 8'h00, 3'd5, 1'b1));
    send_item(make_item(OP_READ, OFS_IRQ, 8'hff, 3'd0, 1'b0));
    send_item(make_item(OP_LINE, 3'd0, 8'h00, 3'd0, 1'b1));
    // level already high, no new edge
    send_item(make_item(OP_LINE, 3'd0, 8'h00, 3'd3, 1'b1));
    send_item(make_item(OP_LINE, 3'd0, 8'h00, 3'd3, 1'b0));
    send_item(make_item(OP_LINE, 3'd7, 8'h00, 3'd7, 1'b1));
    // mask write drops the latched source
    send_item(make_item(OP_WRITE, OFS_IRQ, 8'h00, 3'd7, 1'b1));
    send_item(make_item(OP_LINE, 3'd0, 8'h00, 3'd3, 1'b1));
    send_item(make_item(OP_UNUSED, 3'd7, 8'hff, 3'd7, 1'b1));
    send_item(make_item(OP_WRITE, OFS_LCD_CMD, 8'h5a, 3'd0, 1'b0));
    send_item(make_item(OP_WRITE, OFS_LCD_DATA, 8'ha5, 3'd0, 1'b0));
    send_item(make_item(OP_WRITE, OFS_UNMAPPED_LO, 8'hff, 3'd0, 1'b0));
    send_item(make_item(OP_WRITE, OFS_UNMAPPED_MID, 8'hff, 3'd0, 1'b0));
    send_item(make_item(OP_WRITE, OFS_UNMAPPED_HI, 8'hff, 3'd7, 1'b1));
    send_item(make_item(OP_WRITE, OFS_LCD_CTRL, 8'h00, 3'd0, 1'b0));
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned send_idle,
                                     input int unsigned recv_stall);
    idle_pct = send_idle;
    stall_pct = recv_stall;
    repeat (n_items) send_item(random_item());
    wait_for_drain();
  endtask

  // receiver holds off while the sender keeps offering, so both stages fill
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_end <= cycle_cnt + 60;
    repeat (40) send_item(random_item());
    wait_for_drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_window();
    test_random_traffic(420, 0, 0);
    test_backpressure();
    test_random_traffic(420, 45, 0);
    test_random_traffic(420, 0, 45);
    test_random_traffic(420, 33, 33);
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d transfers in, %0d results checked, %0d input stall cycles",
             n_sent, n_checked, n_full_stalls);
    $display("interrupt latches %0d, source reads %0d, lcd forwards %0d, mismatches %0d",
             n_latches, n_src_reads, n_lcd_fwd, err_count);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/gaia_pkg.sv
src/gaia_engine.sv
src/gaia_out_stage.sv
src/gate_array_interrupt_aggregator_core.sv
src/gaia_checker.sv
verif/tb.sv
